>>> design/btad_pkg.sv
// shared constants and the double-dabble step for the binary to ascii decimal unit
package btad_pkg;

	localparam int NUM_BITS       = 32;
	localparam int MAX_DIGITS     = 10;
	localparam int COUNT_W        = 4;
	localparam int CHAR_W         = 6;
	localparam int NUM_STAGES     = 4;
	localparam int BITS_PER_STAGE = NUM_BITS / NUM_STAGES;
	localparam int BCD_W          = 4 * MAX_DIGITS;
	localparam int DIGIT_IDX_W    = $clog2(MAX_DIGITS);

	localparam logic [CHAR_W-1:0]  ASCII_ZERO   = CHAR_W'(48);
	localparam logic [COUNT_W-1:0] COUNT_LIMIT  = COUNT_W'(MAX_DIGITS);

	// shift a slice of binary bits into the bcd accumulator, msb first
	function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd_in,
		input logic [BITS_PER_STAGE-1:0] bits);
		logic [BCD_W-1:0] b;
		b = bcd_in;
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			for (int j = 0; j < MAX_DIGITS; j++) begin
				if (b[j*4 +: 4] >= 4'd5) begin
					b[j*4 +: 4] = b[j*4 +: 4] + 4'd3;
				end
			end
			b = {b[BCD_W-2:0], bits[BITS_PER_STAGE-1-i]};
		end
		return b;
	endfunction

endpackage

>>> design/btad_convert.sv
// four-stage double-dabble pipeline from 32-bit binary to ten bcd digits
module btad_convert (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [btad_pkg::NUM_BITS-1:0]       number,
	input  logic [btad_pkg::COUNT_W-1:0]        digit_count,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [btad_pkg::BCD_W-1:0]          bcd,
	output logic [btad_pkg::COUNT_W-1:0]        count
);

	localparam int BPS    = btad_pkg::BITS_PER_STAGE;
	localparam int REM1_W = btad_pkg::NUM_BITS - BPS;
	localparam int REM2_W = REM1_W - BPS;
	localparam int REM3_W = REM2_W - BPS;

	logic                          v_s1, v_s2, v_s3, v_s4;
	logic                          adv_s1, adv_s2, adv_s3, adv_s4;
	logic [btad_pkg::BCD_W-1:0]    bcd_s1, bcd_s2, bcd_s3, bcd_s4;
	logic [REM1_W-1:0]             rem_s1;
	logic [REM2_W-1:0]             rem_s2;
	logic [REM3_W-1:0]             rem_s3;
	logic [btad_pkg::COUNT_W-1:0]  cnt_s1, cnt_s2, cnt_s3, cnt_s4;
	logic [btad_pkg::COUNT_W-1:0]  cnt_sat;

	// a stage moves when it is empty or the next one moves
	assign adv_s4   = !v_s4 || !out_stall;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	assign cnt_sat = (digit_count > btad_pkg::COUNT_LIMIT) ? btad_pkg::COUNT_LIMIT : digit_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			bcd_s1 <= btad_pkg::dabble('0, number[btad_pkg::NUM_BITS-1 -: BPS]);
			rem_s1 <= number[REM1_W-1:0];
			cnt_s1 <= cnt_sat;
		end
		if (adv_s2) begin
			bcd_s2 <= btad_pkg::dabble(bcd_s1, rem_s1[REM1_W-1 -: BPS]);
			rem_s2 <= rem_s1[REM2_W-1:0];
			cnt_s2 <= cnt_s1;
		end
		if (adv_s3) begin
			bcd_s3 <= btad_pkg::dabble(bcd_s2, rem_s2[REM2_W-1 -: BPS]);
			rem_s3 <= rem_s2[REM3_W-1:0];
			cnt_s3 <= cnt_s2;
		end
		if (adv_s4) begin
			bcd_s4 <= btad_pkg::dabble(bcd_s3, rem_s3[REM3_W-1 -: BPS]);
			cnt_s4 <= cnt_s3;
		end
	end

	assign out_valid = v_s4;
	assign bcd       = bcd_s4;
	assign count     = cnt_s4;

endmodule

>>> design/btad_serializer.sv
// emits the low digits of a bcd word as ascii characters, most significant first
module btad_serializer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [btad_pkg::BCD_W-1:0]         bcd,
	input  logic [btad_pkg::COUNT_W-1:0]       count,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [btad_pkg::CHAR_W-1:0]        ascii_char,
	output logic                               last
);

	logic [btad_pkg::BCD_W-1:0]       bcd_q;
	logic [btad_pkg::COUNT_W-1:0]     cnt_q;
	logic [btad_pkg::COUNT_W-1:0]     idx;
	logic [3:0]                       digit;
	logic                             load;

	// take a new word when idle or when the final digit leaves this cycle
	assign load     = (cnt_q == '0) || ((cnt_q == btad_pkg::COUNT_W'(1)) && !out_stall);
	assign in_stall = !load;

	assign idx = cnt_q - btad_pkg::COUNT_W'(1);

	always_comb begin
		digit = '0;
		for (int j = 0; j < btad_pkg::MAX_DIGITS; j++) begin
			if (idx == btad_pkg::COUNT_W'(j)) begin
				digit = bcd_q[j*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= in_valid ? count : '0;
		end else if (!out_stall) begin
			cnt_q <= idx;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			bcd_q <= bcd;
		end
	end

	assign out_valid  = (cnt_q != '0);
	assign ascii_char = btad_pkg::ASCII_ZERO + {2'b00, digit};
	assign last       = (cnt_q == btad_pkg::COUNT_W'(1));

endmodule

>>> design/binary_to_ascii_decimal_unit.sv
// top level: prints a 32-bit unsigned number as a run of ascii decimal characters
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_stall, number, digit_count | into block
//  output  | out_valid, out_stall, ascii_char, last  | out of block
//
// each input transaction yields min(digit_count, 10) output transactions;
// a count of zero yields none
// the path from input to first character runs through four double-dabble
// stages of eight bits each, then the character register
// sustained throughput is set by the single character output; the pipeline
// keeps converting the next items meanwhile
// arst_n clears every valid bit and the character counter; data registers keep garbage
// a stall on the output backs up stage by stage and nothing is lost or repeated
module binary_to_ascii_decimal_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [btad_pkg::NUM_BITS-1:0]      number,
	input  logic [btad_pkg::COUNT_W-1:0]       digit_count,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [btad_pkg::CHAR_W-1:0]        ascii_char,
	output logic                               last
);

	// converted transaction between the dabble pipeline and the serializer
	logic                              conv_valid;
	logic                              conv_stall;
	logic [btad_pkg::BCD_W-1:0]        conv_bcd;
	logic [btad_pkg::COUNT_W-1:0]      conv_count;

	// binary to bcd, count saturated to ten digits on entry
	btad_convert u_convert (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.number      (number),
		.digit_count (digit_count),
		.out_valid   (conv_valid),
		.out_stall   (conv_stall),
		.bcd         (conv_bcd),
		.count       (conv_count)
	);

	// one digit per output transaction, last flag on the final one
	btad_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (conv_valid),
		.in_stall   (conv_stall),
		.bcd        (conv_bcd),
		.count      (conv_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ascii_char (ascii_char),
		.last       (last)
	);

endmodule

>>> bench/testbench.sv
// self-checking testbench for binary_to_ascii_decimal_unit: random traffic, random stalls
module testbench;

	import btad_pkg::*;

	localparam int RANDOM_ITEMS = 370;
	localparam int DRAIN_CYCLES = 40;
	localparam int LIMIT_CYCLES = 200000;
	localparam int IDLE_PCT     = 24;
	// window of input transactions during which neither side idles
	localparam int CALM_FROM    = 150;
	localparam int CALM_TO      = 240;

	typedef struct packed {
		logic [NUM_BITS-1:0] value;
		logic [COUNT_W-1:0]  count;
	} conversion_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} digit_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic [NUM_BITS-1:0] number      = '0;
	logic [COUNT_W-1:0]  digit_count = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic [CHAR_W-1:0]   ascii_char;
	logic                last;

	conversion_t conversions_todo[$];
	digit_t      digits_due[$];
	conversion_t next_conv;
	digit_t      want;
	int          sent_count  = 0;
	int          errors      = 0;
	int          cycle_count = 0;
	logic        calm;

	assign calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);

	binary_to_ascii_decimal_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.number      (number),
		.digit_count (digit_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ascii_char  (ascii_char),
		.last        (last)
	);

	always #5 clk = ~clk;

	// expected characters of one conversion, most significant digit first
	function automatic void spell_decimal(input logic [NUM_BITS-1:0] value,
		input logic [COUNT_W-1:0] count);
		logic [3:0]          digs[MAX_DIGITS];
		logic [NUM_BITS-1:0] rest;
		int                  n;
		digit_t              d;
		n = (count > COUNT_W'(MAX_DIGITS)) ? MAX_DIGITS : int'(count);
		rest = value;
		for (int k = 0; k < n; k++) begin
			digs[k] = 4'(rest % 10);
			rest    = rest / 10;
		end
		for (int k = 0; k < n; k++) begin
			d.ch   = CHAR_W'(digs[n-1-k]) + CHAR_W'(48);
			d.last = (k == n - 1);
			digits_due.push_back(d);
		end
	endfunction

	function automatic conversion_t conv(input logic [NUM_BITS-1:0] value, input int count);
		conversion_t c;
		c.value = value;
		c.count = COUNT_W'(count);
		return c;
	endfunction

	// input driver: takes the next pending transaction when the channel is free
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			number      <= '0;
			digit_count <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				spell_decimal(number, digit_count);
				sent_count <= sent_count + 1;
			end
			// a stalled payload holds, otherwise present the next item or idle
			if (!in_valid || !in_stall) begin
				if (conversions_todo.size() > 0 &&
					(calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_conv    = conversions_todo.pop_front();
					in_valid    <= 1'b1;
					number      <= next_conv.value;
					digit_count <= next_conv.count;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: every accepted character against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (digits_due.size() == 0) begin
					$display("%0t: unexpected character: expected none, actual char=%0d last=%0b",
						$time, ascii_char, last);
					errors = errors + 1;
				end else begin
					want = digits_due.pop_front();
					if (ascii_char !== want.ch) begin
						$display("%0t: ascii_char mismatch: expected %0d, actual %0d",
							$time, want.ch, ascii_char);
						errors = errors + 1;
					end
					if (last !== want.last) begin
						$display("%0t: last mismatch: expected %0b, actual %0b",
							$time, want.last, last);
						errors = errors + 1;
					end
				end
			end
			out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("[binary_to_ascii_decimal_unit] ERROR");
			$finish;
		end
	end

	initial begin
		logic [NUM_BITS-1:0] v;
		int                  cnt;

		// directed: field extremes, zero count, padding and truncation
		conversions_todo.push_back(conv(32'd0, 10));
		conversions_todo.push_back(conv(32'hFFFF_FFFF, 10));
		conversions_todo.push_back(conv(32'hFFFF_FFFF, 0));
		conversions_todo.push_back(conv(32'd0, 0));
		conversions_todo.push_back(conv(32'd7, 1));
		conversions_todo.push_back(conv(32'd9, 1));
		conversions_todo.push_back(conv(32'd1234567890, 10));
		conversions_todo.push_back(conv(32'd7, 5));              // padded with zeros
		conversions_todo.push_back(conv(32'hFFFF_FFFF, 3));      // truncated to low digits
		conversions_todo.push_back(conv(32'd1000000000, 10));
		conversions_todo.push_back(conv(32'd999999999, 9));
		conversions_todo.push_back(conv(32'd999999999, 10));
		conversions_todo.push_back(conv(32'd4000000000, 10));
		conversions_todo.push_back(conv(32'd42, 0));
		conversions_todo.push_back(conv(32'd42, 2));
		conversions_todo.push_back(conv(32'h8000_0000, 8));
		conversions_todo.push_back(conv(32'h5555_5555, 4));
		conversions_todo.push_back(conv(32'hAAAA_AAAA, 6));
		conversions_todo.push_back(conv(32'd123, 7));

		// random: mix of full-width, small and boundary numbers
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case ($urandom_range(0, 5))
				0:       v = $urandom_range(0, 999);
				1:       v = 32'hFFFF_FFFF - $urandom_range(0, 15);
				2:       v = 32'd999999999 + $urandom_range(0, 2) - 1;
				default: v = $urandom;
			endcase
			cnt = ($urandom_range(0, 3) == 0) ? MAX_DIGITS : $urandom_range(0, MAX_DIGITS);
			conversions_todo.push_back(conv(v, cnt));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every item to be taken, then for its characters
		while (conversions_todo.size() > 0 || in_valid) @(posedge clk);
		while (digits_due.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("[binary_to_ascii_decimal_unit] OK");
		end else begin
			$display("[binary_to_ascii_decimal_unit] ERROR");
		end
		$finish;
	end

endmodule

>>> sim.f
design/btad_pkg.sv
design/btad_convert.sv
design/btad_serializer.sv
design/binary_to_ascii_decimal_unit.sv
bench/testbench.sv
